// ===== design/gregorian_date_step_unit_assert.svh =====
// Assertion macros shared by the date step unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GREGORIAN_DATE_STEP_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_STEP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gds: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gds: next-cycle check failed");

`endif

// ===== design/gds_pkg.sv =====
package gds_pkg;

    typedef enum logic [1:0] {
        CMD_NEXT = 2'd0,
        CMD_PREV = 2'd1,
        CMD_DOY  = 2'd2
    } cmd_t;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  DAY_FIRST = 5'd1;
    localparam logic [4:0]  DEC_DAYS  = 5'd31;
    localparam logic [15:0] YEAR_MAX  = 16'hFFFF;

    // 25 * INV25 == 1 modulo 2^16, so y is a multiple of 25 exactly when
    // y * INV25 (mod 2^16) is no larger than floor(65535 / 25).
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'(65535 / 25);

    typedef struct packed {
        cmd_t        command;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } req_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] y_mul;
    } s1_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  dim;
        logic        leap;
    } s2_t;

    typedef struct packed {
        logic [15:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [8:0]  day_of_year;
        logic        year_wrapped;
    } rsp_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] acc;
        unique case (m)
            4'd2:    acc = 9'd31;
            4'd3:    acc = 9'd59;
            4'd4:    acc = 9'd90;
            4'd5:    acc = 9'd120;
            4'd6:    acc = 9'd151;
            4'd7:    acc = 9'd181;
            4'd8:    acc = 9'd212;
            4'd9:    acc = 9'd243;
            4'd10:   acc = 9'd273;
            4'd11:   acc = 9'd304;
            4'd12:   acc = 9'd334;
            default: acc = 9'd0;
        endcase
        return acc;
    endfunction

endpackage

// ===== design/gds_if.sv =====
interface gds_req_if;
    import gds_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;

    modport source (output valid, command, year, month, day, input ready);
    modport sink   (input valid, command, year, month, day, output ready);
endinterface

interface gds_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [8:0]  day_of_year;
    logic        year_wrapped;

    modport source (output valid, out_year, out_month, out_day, day_of_year, year_wrapped,
                    input ready);
    modport sink   (input valid, out_year, out_month, out_day, day_of_year, year_wrapped,
                    output ready);
endinterface

// ===== design/gds_prep.sv =====
module gds_prep (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  gds_pkg::req_t  item,
    output logic           res_valid,
    input  logic           res_ready,
    output gds_pkg::s1_t   res
);
    import gds_pkg::*;

    logic        valid_reg;
    s1_t         data_reg;
    s1_t         data_next;
    logic [15:0] prod;

    // Months outside 1..12 are pinned to the nearest end of the range.
    always_comb
    begin
        prod              = item.year * INV25;
        data_next.command = item.command;
        data_next.year    = item.year;
        data_next.day     = item.day;
        data_next.y_mul   = prod;
        if (item.month < MONTH_JAN)
            data_next.month = MONTH_JAN;
        else if (item.month > MONTH_DEC)
            data_next.month = MONTH_DEC;
        else
            data_next.month = item.month;
    end

    assign item_ready = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item_ready)
            valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;
endmodule

// ===== design/gds_clamp.sv =====
module gds_clamp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  gds_pkg::s1_t  item,
    output logic          res_valid,
    input  logic          res_ready,
    output gds_pkg::s2_t  res
);
    import gds_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;
    logic div4;
    logic div16;
    logic div25;
    logic leap;
    logic [4:0] dim;

    // Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
    always_comb
    begin
        div4  = (item.year[1:0] == 2'd0);
        div16 = (item.year[3:0] == 4'd0);
        div25 = (item.y_mul <= DIV25_LIMIT);
        leap  = (div4 && !div25) || (div16 && div25);
        dim   = month_days(item.month, leap);

        data_next.command = item.command;
        data_next.year    = item.year;
        data_next.month   = item.month;
        data_next.dim     = dim;
        data_next.leap    = leap;
        if (item.day < DAY_FIRST)
            data_next.day = DAY_FIRST;
        else if (item.day > dim)
            data_next.day = dim;
        else
            data_next.day = item.day;
    end

    assign item_ready = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item_ready)
            valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;
endmodule

// ===== design/gds_step.sv =====
module gds_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  gds_pkg::s2_t  item,
    output logic          res_valid,
    input  logic          res_ready,
    output gds_pkg::rsp_t res
);
    import gds_pkg::*;

    logic valid_reg;
    rsp_t data_reg;
    rsp_t data_next;
    logic [3:0] prev_month;
    logic       leap_bump;

    always_comb
    begin
        prev_month = item.month - 4'd1;
        leap_bump  = (item.month > MONTH_FEB) && item.leap;

        data_next.out_year     = item.year;
        data_next.out_month    = item.month;
        data_next.out_day      = item.day;
        data_next.day_of_year  = 9'd0;
        data_next.year_wrapped = 1'b0;

        case (item.command)
            CMD_NEXT:
            begin
                if (item.day < item.dim)
                    data_next.out_day = item.day + 5'd1;
                else
                begin
                    data_next.out_day = DAY_FIRST;
                    if (item.month == MONTH_DEC)
                    begin
                        data_next.out_month    = MONTH_JAN;
                        data_next.out_year     = item.year + 16'd1;
                        data_next.year_wrapped = (item.year == YEAR_MAX);
                    end
                    else
                        data_next.out_month = item.month + 4'd1;
                end
            end
            CMD_PREV:
            begin
                if (item.day > DAY_FIRST)
                    data_next.out_day = item.day - 5'd1;
                else if (item.month == MONTH_JAN)
                begin
                    data_next.out_month    = MONTH_DEC;
                    data_next.out_day      = DEC_DAYS;
                    data_next.out_year     = item.year - 16'd1;
                    data_next.year_wrapped = (item.year == 16'd0);
                end
                else
                begin
                    // Stepping back stays within the year, so its leap flag holds.
                    data_next.out_month = prev_month;
                    data_next.out_day   = month_days(prev_month, item.leap);
                end
            end
            CMD_DOY:
            begin
                data_next.day_of_year = days_before(item.month)
                                      + {4'd0, item.day} - 9'd1
                                      + {8'd0, leap_bump};
            end
            default:
            begin
                data_next.day_of_year = 9'd0;
            end
        endcase
    end

    assign item_ready = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item_ready)
            valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            data_reg <= data_next;
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;
endmodule

// ===== design/gregorian_date_step_unit.sv =====
// An accepted request is registered in gds_prep, gds_clamp and gds_step in turn.
// Throughput: one transaction per cycle while rsp.ready holds; the reciprocal
// multiply for the divisible-by-25 test sets the depth of the first stage.
// Reset: rst_n is asynchronous and active low; it clears all stage valid bits,
// and payload registers are left as they are.
`include "gregorian_date_step_unit_assert.svh"

module gregorian_date_step_unit (
    input  logic         clk,
    input  logic         rst_n,
    gds_req_if.sink      req,
    gds_rsp_if.source    rsp
);
    import gds_pkg::*;

    // The unit is a three-stage pipeline:
    //   gds_prep  - clamps the month and multiplies the year by the inverse
    //               of 25 modulo 2^16.
    //   gds_clamp - finishes the leap-year test, looks up the month length
    //               and clamps the day into the month.
    //   gds_step  - next day, previous day, day of year, or an echo of the date.
    // Each stage may take a new transaction when it is empty or when the
    // stage below takes its current one, so bubbles collapse and a stall at
    // the response side backs up without losing or repeating anything.

    req_t req_data;
    s1_t  s1_data;
    s2_t  s2_data;
    rsp_t rsp_data;
    logic s1_valid;
    logic s1_ready;
    logic s2_valid;
    logic s2_ready;

    always_comb
    begin
        req_data.command = cmd_t'(req.command);
        req_data.year    = req.year;
        req_data.month   = req.month;
        req_data.day     = req.day;
    end

    gds_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (req.ready),
        .item       (req_data),
        .res_valid  (s1_valid),
        .res_ready  (s1_ready),
        .res        (s1_data)
    );

    gds_clamp u_clamp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid),
        .item_ready (s1_ready),
        .item       (s1_data),
        .res_valid  (s2_valid),
        .res_ready  (s2_ready),
        .res        (s2_data)
    );

    gds_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s2_valid),
        .item_ready (s2_ready),
        .item       (s2_data),
        .res_valid  (rsp.valid),
        .res_ready  (rsp.ready),
        .res        (rsp_data)
    );

    assign rsp.out_year     = rsp_data.out_year;
    assign rsp.out_month    = rsp_data.out_month;
    assign rsp.out_day      = rsp_data.out_day;
    assign rsp.day_of_year  = rsp_data.day_of_year;
    assign rsp.year_wrapped = rsp_data.year_wrapped;

    // A wrap can only land on one of the two dates at the ends of the year range.
    `GDS_ASSERT_SAME(a_wrap_date, rsp.valid && rsp.year_wrapped,
        (rsp.out_year == 16'd0 && rsp.out_month == MONTH_JAN && rsp.out_day == DAY_FIRST) ||
        (rsp.out_year == YEAR_MAX && rsp.out_month == MONTH_DEC && rsp.out_day == DEC_DAYS))

    // Every response carries a month in range, a day of at least one and a day of year in range.
    `GDS_ASSERT_SAME(a_date_range, rsp.valid,
        rsp.out_month >= MONTH_JAN && rsp.out_month <= MONTH_DEC &&
        rsp.out_day >= DAY_FIRST && rsp.day_of_year <= 9'd365)

    // A full middle stage that is held back must still be full next cycle.
    `GDS_ASSERT_NEXT(a_s2_hold, s2_valid && !s2_ready, s2_valid)
endmodule

// ===== test/gregorian_date_step_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Gregorian date step unit.
//
// Every request transaction that the unit accepts is run through a predictor
// that this bench keeps of its own, unless a row pins a typed response, and
// the expected response is queued. Every response transaction that the bench
// accepts is compared, field by field, with the oldest queued expectation. A
// short directed table comes first, then about a thousand random dates. Both
// sides of the unit idle at random, but for one long stretch with no idling at all.
module gregorian_date_step_unit_tb;

    import gds_pkg::*;

    // Command code that the package leaves unnamed. The unit treats it as an
    // echo of the corrected date.
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam int RANDOM_DATES   = 1000;
    localparam int IDLE_PERCENT   = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // One row of the directed table. When pinned is set, want holds a
    // response typed in by hand; otherwise the predictor supplies it.
    typedef struct {
        logic [1:0]  command;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        bit          pinned;
        rsp_t        want;
    } date_row_t;

    logic clk;
    logic rst_n;

    gds_req_if req_bus ();
    gds_rsp_if rsp_bus ();

    gregorian_date_step_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Responses still owed by the unit, oldest first.
    rsp_t      expected_dates[$];
    date_row_t date_rows[$];

    // The driver hands a hand-typed expectation to the monitor through these.
    bit   pin_active;
    rsp_t pin_rsp;

    bit   stall_enable;
    int   mismatch_count;
    int   quiet_cycles;
    rsp_t want_date;

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit leap_year(input logic [15:0] y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic logic [4:0] month_length(input logic [15:0] y, input logic [3:0] m);
        if (m == MONTH_FEB)
            return leap_year(y) ? 5'd29 : 5'd28;
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
            return 5'd30;
        return 5'd31;
    endfunction

    // Works out the response for one date. Month and day are first pulled
    // into range, which every command sees, including the reserved one.
    function automatic rsp_t predict_date(input logic [1:0] cmd, input logic [15:0] y_in,
                                          input logic [3:0] m_in, input logic [4:0] d_in);
        logic [15:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [4:0]  dim;
        logic [8:0]  ordinal;
        logic        wrapped;
        rsp_t        r;
        y       = y_in;
        m       = m_in;
        d       = d_in;
        ordinal = '0;
        wrapped = 1'b0;
        if (m < MONTH_JAN)
            m = MONTH_JAN;
        if (m > MONTH_DEC)
            m = MONTH_DEC;
        dim = month_length(y, m);
        if (d < DAY_FIRST)
            d = DAY_FIRST;
        if (d > dim)
            d = dim;

        case (cmd)
            CMD_NEXT:
            begin
                if (d < dim)
                    d = d + 5'd1;
                else
                begin
                    d = DAY_FIRST;
                    if (m == MONTH_DEC)
                    begin
                        m       = MONTH_JAN;
                        wrapped = (y == YEAR_MAX);
                        y       = y + 16'd1;
                    end
                    else
                        m = m + 4'd1;
                end
            end
            CMD_PREV:
            begin
                if (d > DAY_FIRST)
                    d = d - 5'd1;
                else
                begin
                    if (m == MONTH_JAN)
                    begin
                        m       = MONTH_DEC;
                        wrapped = (y == 16'd0);
                        y       = y - 16'd1;
                    end
                    else
                        m = m - 4'd1;
                    d = month_length(y, m);
                end
            end
            CMD_DOY:
            begin
                // Walk the months ahead of this one rather than looking up a
                // cumulative table, so the check does not share its form.
                for (int k = 1; k < 12; k++)
                    if (k < m)
                        ordinal = ordinal + 9'(month_length(y, 4'(k)));
                ordinal = ordinal + 9'(d) - 9'd1;
            end
            default:
            begin
            end
        endcase

        r.out_year     = y;
        r.out_month    = m;
        r.out_day      = d;
        r.day_of_year  = ordinal;
        r.year_wrapped = wrapped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic [15:0] y, input logic [3:0] m,
                           input logic [4:0] d, input bit pinned, input logic [15:0] oy,
                           input logic [3:0] om, input logic [4:0] od, input logic [8:0] doy,
                           input logic wrap);
        date_row_t row;
        row.command           = cmd;
        row.year              = y;
        row.month             = m;
        row.day               = d;
        row.pinned            = pinned;
        row.want.out_year     = oy;
        row.want.out_month    = om;
        row.want.out_day      = od;
        row.want.day_of_year  = doy;
        row.want.year_wrapped = wrap;
        date_rows.push_back(row);
    endtask

    // Offers one request transaction, starting at a falling edge, and returns
    // at the falling edge after it has been accepted. When idling is enabled
    // the request is held back for a random number of cycles first. Valid is
    // only ever written once per time step, so back-to-back transactions keep
    // it high without a glitch.
    task automatic send_date(input logic [1:0] cmd, input logic [15:0] y, input logic [3:0] m,
                             input logic [4:0] d, input bit pinned, input rsp_t want);
        while (stall_enable && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_bus.valid = 1'b0;
            @(negedge clk);
        end
        req_bus.command = cmd;
        req_bus.year    = y;
        req_bus.month   = m;
        req_bus.day     = d;
        pin_active      = pinned;
        pin_rsp         = want;
        req_bus.valid   = 1'b1;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, driven at the falling edge.
    // ------------------------------------------------------------------

    always @(negedge clk)
        rsp_bus.ready = rst_n && (!stall_enable || $urandom_range(0, 99) >= IDLE_PERCENT);

    // ------------------------------------------------------------------
    // Monitor and scoreboard. Everything is sampled at the rising edge, where
    // the values seen are the ones that the unit itself samples.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // An accepted request is predicted first, so that even a response
            // in the same cycle would find its expectation waiting.
            if (req_bus.valid && req_bus.ready)
            begin
                if (pin_active)
                    expected_dates.push_back(pin_rsp);
                else
                    expected_dates.push_back(predict_date(req_bus.command, req_bus.year,
                                                          req_bus.month, req_bus.day));
            end

            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_dates.size() == 0)
                    report_mismatch($sformatf("response %0d-%0d-%0d with nothing outstanding",
                                              rsp_bus.out_year, rsp_bus.out_month,
                                              rsp_bus.out_day));
                else
                begin
                    want_date = expected_dates.pop_front();
                    if (rsp_bus.out_year !== want_date.out_year)
                        report_mismatch($sformatf("out_year got %0d expected %0d",
                                                  rsp_bus.out_year, want_date.out_year));
                    if (rsp_bus.out_month !== want_date.out_month)
                        report_mismatch($sformatf("out_month got %0d expected %0d",
                                                  rsp_bus.out_month, want_date.out_month));
                    if (rsp_bus.out_day !== want_date.out_day)
                        report_mismatch($sformatf("out_day got %0d expected %0d",
                                                  rsp_bus.out_day, want_date.out_day));
                    if (rsp_bus.day_of_year !== want_date.day_of_year)
                        report_mismatch($sformatf("day_of_year got %0d expected %0d",
                                                  rsp_bus.day_of_year, want_date.day_of_year));
                    if (rsp_bus.year_wrapped !== want_date.year_wrapped)
                        report_mismatch($sformatf("year_wrapped got %0b expected %0b",
                                                  rsp_bus.year_wrapped,
                                                  want_date.year_wrapped));
                end
            end

            // The watchdog counts cycles in which no transaction moves on
            // either side. Random idling never comes close to the limit, so
            // reaching it means the unit has hung.
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d responses owed",
                         $realtime, quiet_cycles, expected_dates.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        logic [1:0]  cmd;
        logic [15:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        int          sel;
        rsp_t        unused;

        clk             = 1'b0;
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_NEXT;
        req_bus.year    = '0;
        req_bus.month   = MONTH_JAN;
        req_bus.day     = DAY_FIRST;
        rsp_bus.ready   = 1'b0;
        pin_active      = 1'b0;
        pin_rsp         = '0;
        unused          = '0;
        stall_enable    = 1'b1;
        mismatch_count  = 0;
        quiet_cycles    = 0;

        // Directed table. Rows with a typed response cover the year wraps,
        // the leap rules (century years and year 0 included), the ends of
        // the year, and the clamping of out-of-range month and day. The rest
        // go to the predictor.
        add_row(CMD_NEXT, 16'hFFFF, 4'd12, 5'd31, 1, 16'd0, 4'd1, 5'd1, 9'd0, 1'b1);
        add_row(CMD_PREV, 16'd0, 4'd1, 5'd1, 1, 16'hFFFF, 4'd12, 5'd31, 9'd0, 1'b1);
        add_row(CMD_DOY, 16'd2024, 4'd12, 5'd31, 1, 16'd2024, 4'd12, 5'd31, 9'd365, 1'b0);
        add_row(CMD_DOY, 16'd2023, 4'd1, 5'd1, 1, 16'd2023, 4'd1, 5'd1, 9'd0, 1'b0);
        add_row(CMD_NEXT, 16'd2024, 4'd2, 5'd28, 1, 16'd2024, 4'd2, 5'd29, 9'd0, 1'b0);
        add_row(CMD_NEXT, 16'd2023, 4'd2, 5'd28, 1, 16'd2023, 4'd3, 5'd1, 9'd0, 1'b0);
        add_row(CMD_NEXT, 16'd1900, 4'd2, 5'd28, 1, 16'd1900, 4'd3, 5'd1, 9'd0, 1'b0);
        add_row(CMD_NEXT, 16'd2000, 4'd2, 5'd28, 1, 16'd2000, 4'd2, 5'd29, 9'd0, 1'b0);
        add_row(CMD_PREV, 16'd2024, 4'd3, 5'd1, 1, 16'd2024, 4'd2, 5'd29, 9'd0, 1'b0);
        add_row(CMD_PREV, 16'd0, 4'd3, 5'd1, 1, 16'd0, 4'd2, 5'd29, 9'd0, 1'b0);
        // Month zero is read as January, months above twelve as December.
        add_row(CMD_NEXT, 16'd2021, 4'd0, 5'd5, 1, 16'd2021, 4'd1, 5'd6, 9'd0, 1'b0);
        add_row(CMD_DOY, 16'd2021, 4'd15, 5'd31, 1, 16'd2021, 4'd12, 5'd31, 9'd364, 1'b0);
        // Day zero is read as the first; a day past the month end as the last.
        add_row(CMD_PREV, 16'd2021, 4'd5, 5'd0, 1, 16'd2021, 4'd4, 5'd30, 9'd0, 1'b0);
        add_row(CMD_NEXT, 16'd2021, 4'd2, 5'd31, 1, 16'd2021, 4'd3, 5'd1, 9'd0, 1'b0);
        // The reserved command only echoes the corrected date.
        add_row(CMD_RESERVED, 16'd2024, 4'd13, 5'd0, 1, 16'd2024, 4'd12, 5'd1, 9'd0, 1'b0);
        add_row(CMD_RESERVED, 16'hFFFF, 4'd2, 5'd31, 1, 16'hFFFF, 4'd2, 5'd28, 9'd0, 1'b0);
        add_row(CMD_NEXT, 16'hFFFF, 4'd12, 5'd30, 1, 16'hFFFF, 4'd12, 5'd31, 9'd0, 1'b0);
        add_row(CMD_PREV, 16'hFFFF, 4'd1, 5'd1, 1, 16'hFFFE, 4'd12, 5'd31, 9'd0, 1'b0);
        add_row(CMD_DOY, 16'd2000, 4'd3, 5'd1, 1, 16'd2000, 4'd3, 5'd1, 9'd60, 1'b0);
        add_row(CMD_DOY, 16'd1900, 4'd3, 5'd1, 1, 16'd1900, 4'd3, 5'd1, 9'd59, 1'b0);
        add_row(CMD_DOY, 16'd0, 4'd12, 5'd31, 1, 16'd0, 4'd12, 5'd31, 9'd365, 1'b0);
        add_row(CMD_NEXT, 16'd2021, 4'd4, 5'd30, 0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_PREV, 16'd2021, 4'd8, 5'd1, 0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_DOY, 16'hAAAA, 4'd10, 5'd21, 0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_NEXT, 16'h5555, 4'd5, 5'd10, 0, '0, '0, '0, '0, 1'b0);

        // Reset is released at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (date_rows[i])
            send_date(date_rows[i].command, date_rows[i].year, date_rows[i].month,
                      date_rows[i].day, date_rows[i].pinned, date_rows[i].want);

        // Random dates. Years lean toward the wrap points and the century
        // rules, days toward the month ends where roll-overs happen, and a
        // small share of months, days and commands lie outside the normal
        // range.
        for (int n = 0; n < RANDOM_DATES; n++)
        begin
            // A long stretch with no idling on either side.
            stall_enable = !(n >= 400 && n < 600);

            // Once, the sender holds off until every response has come back,
            // so the unit runs completely empty and refills.
            if (n == 700)
            begin
                req_bus.valid = 1'b0;
                while (expected_dates.size() != 0)
                    @(negedge clk);
            end

            sel = $urandom_range(0, 99);
            if (sel < 5)
                cmd = CMD_RESERVED;
            else
                cmd = 2'($urandom_range(0, 2));

            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                case ($urandom_range(0, 3))
                    0:       y = 16'd0;
                    1:       y = 16'd1;
                    2:       y = 16'hFFFE;
                    default: y = YEAR_MAX;
                endcase
            end
            else if (sel < 35)
                y = 16'(100 * $urandom_range(0, 655));
            else if (sel < 50)
                y = 16'(4 * $urandom_range(0, 16383));
            else
                y = 16'($urandom);

            sel = $urandom_range(0, 99);
            if (sel < 3)
                m = 4'd0;
            else if (sel < 6)
                m = 4'($urandom_range(13, 15));
            else if (sel < 21)
            begin
                case ($urandom_range(0, 3))
                    0:       m = MONTH_JAN;
                    1:       m = MONTH_FEB;
                    2:       m = 4'd3;
                    default: m = MONTH_DEC;
                endcase
            end
            else
                m = 4'($urandom_range(1, 12));

            sel = $urandom_range(0, 99);
            if (sel < 4)
                d = 5'd0;
            else if (sel < 30)
                d = DAY_FIRST;
            else if (sel < 60)
                d = 5'($urandom_range(28, 31));
            else
                d = 5'($urandom_range(1, 31));

            send_date(cmd, y, m, d, 1'b0, unused);
        end

        // Stop offering, let every owed response arrive, then keep watching for
        // anything that should not be there.
        req_bus.valid = 1'b0;
        stall_enable  = 1'b1;
        while (expected_dates.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
